// ===== src/pwtr_pkg.sv =====
package pwtr_pkg;

    // Physical address width; sums into physical addresses wrap here.
    localparam int PHYS_ADDR_BITS = 52;
    localparam logic [51:0] PA_MASK = (52'(1) << PHYS_ADDR_BITS) - 52'(1);

    // Input kinds carried on s_tuser.
    localparam logic [1:0] KIND_TRANSLATE = 2'd0;
    localparam logic [1:0] KIND_REMAP     = 2'd1;
    localparam logic [1:0] KIND_READ_RET  = 2'd2;

    // Result kinds carried on m_tuser.
    localparam logic [1:0] RES_READ       = 2'd0;
    localparam logic [1:0] RES_WRITE      = 2'd1;
    localparam logic [1:0] RES_XLATE_DONE = 2'd2;
    localparam logic [1:0] RES_REMAP_DONE = 2'd3;

    // Page table entry bits.
    localparam int PTE_PRESENT_BIT = 0;
    localparam int PTE_LARGE_BIT   = 7;
    localparam logic [63:0] PTE_KEEP_MASK = 64'hFFF0_0000_0000_0FFF;

    // Result queue, depth must be a power of two.
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    typedef struct packed {
        logic [1:0]  kind;
        logic [51:0] root_base;
        logic [47:0] virt_addr;
        logic [51:0] new_frame;
        logic [63:0] read_data;
    } req_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [51:0] mem_addr;
        logic [63:0] write_data;
        logic [51:0] phys_addr;
        logic        fault;
        logic [51:0] old_frame;
        logic        last;
    } res_t;

    typedef struct packed {
        logic [1:0] count;
        res_t       first;
        res_t       second;
    } walk_out_t;

    // Nine-bit table index of the given walk level (3 is the top table).
    function automatic logic [8:0] level_index(logic [47:0] va, logic [1:0] lvl);
        logic [8:0] idx;
        unique case (lvl)
            2'd3:    idx = va[47:39];
            2'd2:    idx = va[38:30];
            2'd1:    idx = va[29:21];
            default: idx = va[20:12];
        endcase
        return idx;
    endfunction

    function automatic logic [51:0] entry_address(logic [51:0] base, logic [8:0] idx);
        return (base + {40'd0, idx, 3'd0}) & PA_MASK;
    endfunction

endpackage

// ===== src/pwtr_walk.sv =====
module pwtr_walk
    import pwtr_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      fire,
    input  req_t      req,
    output walk_out_t walk_out
);

    logic        active_reg, active_next;
    logic        remap_reg, remap_next;
    logic [1:0]  level_reg, level_next;
    logic [47:0] vaddr_reg, vaddr_next;
    logic [39:0] frame_reg, frame_next;
    logic [51:0] entry_reg, entry_next;

    logic [51:0] pte_frame;
    logic        present;
    logic        large_page;
    logic        descend;
    logic [1:0]  lower_level;
    logic [51:0] offset;

    assign pte_frame   = {req.read_data[51:12], 12'd0};
    assign present     = req.read_data[PTE_PRESENT_BIT];
    assign large_page  = req.read_data[PTE_LARGE_BIT];
    assign lower_level = level_reg - 2'd1;

    always_comb begin
        active_next = active_reg;
        remap_next  = remap_reg;
        level_next  = level_reg;
        vaddr_next  = vaddr_reg;
        frame_next  = frame_reg;
        entry_next  = entry_reg;
        walk_out    = '0;
        descend     = 1'b0;
        offset      = '0;

        if (fire) begin
            if (req.kind == KIND_TRANSLATE || req.kind == KIND_REMAP) begin
                if (!active_reg) begin
                    active_next = 1'b1;
                    remap_next  = (req.kind == KIND_REMAP);
                    level_next  = 2'd3;
                    vaddr_next  = req.virt_addr;
                    frame_next  = req.new_frame[51:12];
                    entry_next  = entry_address(req.root_base,
                                                level_index(req.virt_addr, 2'd3));
                    walk_out.count             = 2'd1;
                    walk_out.first.result_kind = RES_READ;
                    walk_out.first.mem_addr    = entry_next;
                    walk_out.first.last        = 1'b1;
                end
            end else if (req.kind == KIND_READ_RET && active_reg) begin
                if (remap_reg) begin
                    if (level_reg != 2'd0) begin
                        if (!present || large_page) begin
                            active_next                = 1'b0;
                            walk_out.count             = 2'd1;
                            walk_out.first.result_kind = RES_REMAP_DONE;
                            walk_out.first.fault       = 1'b1;
                            walk_out.first.last        = 1'b1;
                        end else begin
                            descend = 1'b1;
                        end
                    end else begin
                        // Leaf: write back the entry with its frame replaced.
                        active_next                 = 1'b0;
                        walk_out.count              = 2'd2;
                        walk_out.first.result_kind  = RES_WRITE;
                        walk_out.first.mem_addr     = entry_reg;
                        walk_out.first.write_data   = (req.read_data & PTE_KEEP_MASK)
                                                    | {12'd0, frame_reg, 12'd0};
                        walk_out.second.result_kind = RES_REMAP_DONE;
                        walk_out.second.old_frame   = pte_frame;
                        walk_out.second.last        = 1'b1;
                    end
                end else begin
                    if (level_reg != 2'd0 && !present) begin
                        active_next                = 1'b0;
                        walk_out.count             = 2'd1;
                        walk_out.first.result_kind = RES_XLATE_DONE;
                        walk_out.first.fault       = 1'b1;
                        walk_out.first.last        = 1'b1;
                    end else if (level_reg == 2'd0 || large_page) begin
                        case (level_reg)
                            2'd3:    offset = '0;
                            2'd2:    offset = {22'd0, vaddr_reg[29:0]};
                            2'd1:    offset = {31'd0, vaddr_reg[20:0]};
                            default: offset = {40'd0, vaddr_reg[11:0]};
                        endcase
                        active_next                = 1'b0;
                        walk_out.count             = 2'd1;
                        walk_out.first.result_kind = RES_XLATE_DONE;
                        walk_out.first.phys_addr   = (pte_frame + offset) & PA_MASK;
                        walk_out.first.last        = 1'b1;
                    end else begin
                        descend = 1'b1;
                    end
                end

                if (descend) begin
                    level_next = lower_level;
                    entry_next = entry_address(pte_frame,
                                               level_index(vaddr_reg, lower_level));
                    walk_out.count             = 2'd1;
                    walk_out.first.result_kind = RES_READ;
                    walk_out.first.mem_addr    = entry_next;
                    walk_out.first.last        = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            remap_reg  <= 1'b0;
            level_reg  <= 2'd0;
            vaddr_reg  <= '0;
            frame_reg  <= '0;
            entry_reg  <= '0;
        end else begin
            active_reg <= active_next;
            remap_reg  <= remap_next;
            level_reg  <= level_next;
            vaddr_reg  <= vaddr_next;
            frame_reg  <= frame_next;
            entry_reg  <= entry_next;
        end
    end

endmodule

// ===== src/pwtr_res_fifo.sv =====
module pwtr_res_fifo
    import pwtr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  walk_out_t  push,
    output logic       room,
    output logic       out_valid,
    input  logic       out_ready,
    output res_t       out_data
);

    res_t                 mem [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [OUT_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [OUT_CNT_W-1:0] cnt_reg, cnt_next;
    logic [OUT_PTR_W-1:0] wr_ptr_inc;
    logic                 pop;

    assign room       = (cnt_reg <= OUT_CNT_W'(OUT_DEPTH - 2));
    assign out_valid  = (cnt_reg != '0);
    assign out_data   = mem[rd_ptr_reg];
    assign pop        = out_valid && out_ready;
    assign wr_ptr_inc = wr_ptr_reg + OUT_PTR_W'(1);

    always_comb begin
        wr_ptr_next = wr_ptr_reg + OUT_PTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + OUT_PTR_W'(pop);
        cnt_next    = cnt_reg + OUT_CNT_W'(push.count) - OUT_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2) begin
            mem[wr_ptr_inc] <= push.second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ===== src/page_walk_translate_remap.sv =====
// Four-level page table walker with translate and remap requests.
// The input stream carries one request per transfer: s_tuser selects a
// translate request, a remap request or the return of a table entry read.
// Every walk step produces a read request on the output stream; the
// caller performs the read and sends the entry back as a read return.
// A translate walk ends with a translate-done result (address or fault).
// A remap walk ends with a remap-done result, preceded on success by a
// write request carrying the updated leaf entry.
// A request waits in the input register until the result queue has room.
// Throughput: one input request per cycle while the queue has room;
// the walk logic is a single combinational step between the input
// register and the result queue. A remap completion places two
// results in the queue, which drains one result per cycle, so
// sustained input can briefly slow to its pace.
// Reset clears the walk state, the input register and the result queue.
// When the receiver stalls, results wait in a four-entry queue; once it
// has fewer than two free slots the input register holds and s_tready
// drops, so nothing is ever lost or reordered.
module page_walk_translate_remap
    import pwtr_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,

    input  logic         s_tvalid,
    output logic         s_tready,
    // Fields from bit 0: root_base[51:0], virt_addr[99:52],
    // new_frame[151:100], read_data[215:152].
    input  logic [215:0] s_tdata,
    // Fields from bit 0: kind[1:0].
    input  logic [1:0]   s_tuser,

    output logic         m_tvalid,
    input  logic         m_tready,
    // Fields from bit 0: mem_addr[51:0], write_data[115:52], phys_addr[167:116],
    // fault[168], old_frame[220:169], zero padding[223:221].
    output logic [223:0] m_tdata,
    // Fields from bit 0: result_kind[1:0].
    output logic [1:0]   m_tuser,
    output logic         m_tlast
);

    req_t      req_reg;
    logic      in_valid_reg, in_valid_next;
    logic      room;
    logic      fire;
    logic      s_fire;
    walk_out_t walk_out;
    res_t      head;

    // The held request is processed as soon as the queue can take two
    // results; the input register refills in the same cycle.
    assign fire     = in_valid_reg && room;
    assign s_tready = !in_valid_reg || fire;
    assign s_fire   = s_tvalid && s_tready;

    always_comb begin
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            req_reg.kind      <= s_tuser;
            req_reg.root_base <= s_tdata[51:0];
            req_reg.virt_addr <= s_tdata[99:52];
            req_reg.new_frame <= s_tdata[151:100];
            req_reg.read_data <= s_tdata[215:152];
        end
    end

    pwtr_walk u_walk (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .fire     (fire),
        .req      (req_reg),
        .walk_out (walk_out)
    );

    pwtr_res_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (walk_out),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (head)
    );

    assign m_tdata = {3'd0, head.old_frame, head.fault, head.phys_addr,
                      head.write_data, head.mem_addr};
    assign m_tuser = head.result_kind;
    assign m_tlast = head.last;

endmodule

// ===== src/pwtr_checker.sv =====
module pwtr_checker
    import pwtr_pkg::*;
(
    input logic         aclk,
    input logic         aresetn,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [223:0] m_tdata,
    input logic [1:0]   m_tuser,
    input logic         m_tlast
);

    // A stalled result holds its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
                                  && $stable(m_tuser) && $stable(m_tlast))
        else $error("stalled result changed");

    // The result queue is empty right after reset.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // A write request is never marked last or faulting; its remap-done result follows it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == RES_WRITE |-> !m_tlast && !m_tdata[168])
        else $error("write request marked last or faulting");

    // A read request carries only its entry address and is marked last.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == RES_READ |-> m_tlast && m_tdata[223:52] == '0)
        else $error("read request with stray fields");

endmodule

bind page_walk_translate_remap pwtr_checker u_pwtr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
